@@ sv/mia_pkg.sv @@
`timescale 1ns / 1ps
package mia_pkg;

    // Elements per matrix and cofactor scaling
    localparam int MatSize   = 16;
    localparam int FracShift = 24;

endpackage

@@ sv/mia_loader.sv @@
`timescale 1ns / 1ps
module mia_loader
    import mia_pkg::*;
#(
    parameter int IN_WIDTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [IN_WIDTH-1:0]        in_data,
    input  logic                       eng_busy,
    output logic                       in_stall,
    output logic                       mat_valid,
    output logic [16*IN_WIDTH-1:0]     mat_data,
    input  logic                       mat_take
);

    // Front store and count
    logic [IN_WIDTH-1:0] store_reg [16];
    logic [3:0]          count_reg;
    logic                full_reg;
    logic                xfer;

    // Stall while a full matrix waits for the engine
    assign in_stall  = full_reg;
    assign xfer      = in_valid && !full_reg;
    assign mat_valid = full_reg;

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            store_reg[count_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (xfer)
            begin
                count_reg <= count_reg + 4'd1;
                if (count_reg == 4'd15)
                begin
                    full_reg <= 1'b1;
                end
            end
            else if (mat_take && !eng_busy)
            begin
                full_reg <= 1'b0;
            end
        end
    end

    // Flatten the matrix for the engine
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            mat_data[i*IN_WIDTH +: IN_WIDTH] = store_reg[i];
        end
    end

endmodule

@@ sv/mia_engine.sv @@
`timescale 1ns / 1ps
module mia_engine
    import mia_pkg::*;
#(
    parameter int IN_WIDTH  = 16,
    parameter int OUT_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    mat_valid,
    input  logic [16*IN_WIDTH-1:0]  mat_data,
    output logic                    mat_take,
    output logic                    eng_busy,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [OUT_WIDTH-1:0]    inverse_value,
    output logic [3:0]              element_index,
    output logic                    singular,
    output logic                    saturated,
    output logic                    last
);

    localparam int PW = 2*IN_WIDTH + 1;        // 2x2 minor
    localparam int CW = 3*IN_WIDTH + 3;        // cofactor
    localparam int DW = 4*IN_WIDTH + 5;        // determinant
    localparam int NW = CW + FracShift;        // shifted numerator magnitude
    localparam int QW = NW;
    localparam int QCW = $clog2(QW + 1);

    typedef enum logic [2:0] {S_IDLE, S_COF, S_DET, S_DIV, S_OUT} state_t;

    state_t                    state_reg;
    logic signed [IN_WIDTH-1:0] m_reg [16];
    logic signed [CW-1:0]      cof_reg [16];
    logic signed [DW-1:0]      det_reg;
    logic [3:0]                idx_reg;
    logic [1:0]                step_reg;
    logic signed [PW-1:0]      minor_reg [3];
    logic [QW-1:0]             rem_reg;
    logic [QW-1:0]             quo_reg;
    logic [NW-1:0]             num_reg;
    logic [DW-1:0]             dmag_reg;
    logic [QCW-1:0]            bit_reg;
    logic                      qneg_reg;
    logic                      ovalid_reg;
    logic [OUT_WIDTH-1:0]      oval_reg;
    logic [3:0]                oidx_reg;
    logic                      osing_reg;
    logic                      osat_reg;

    // Rows and columns of the 3x3 submatrix for cofactor (dr, dc)
    logic [1:0] dr, dc;
    logic [1:0] rs [3];
    logic [1:0] cs [3];
    logic signed [IN_WIDTH-1:0] sm [3][3];

    assign dr = idx_reg[3:2];
    assign dc = idx_reg[1:0];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rs[k] = (2'(k) >= dr) ? 2'(k + 1) : 2'(k);
            cs[k] = (2'(k) >= dc) ? 2'(k + 1) : 2'(k);
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                sm[a][b] = m_reg[{cs[b], rs[a]}];
            end
        end
    end

    // All three 2x2 minors in step 0, products in step 1
    logic signed [2*IN_WIDTH-1:0] pp0, pp1, pp2, pp3, pp4, pp5;
    assign pp0 = sm[1][1] * sm[2][2];
    assign pp1 = sm[1][2] * sm[2][1];
    assign pp2 = sm[1][0] * sm[2][2];
    assign pp3 = sm[1][2] * sm[2][0];
    assign pp4 = sm[1][0] * sm[2][1];
    assign pp5 = sm[1][1] * sm[2][0];

    logic signed [PW-1:0] mn0, mn1, mn2;
    assign mn0 = PW'(pp0) - PW'(pp1);
    assign mn1 = PW'(pp2) - PW'(pp3);
    assign mn2 = PW'(pp4) - PW'(pp5);

    logic signed [IN_WIDTH+PW-1:0] cp0, cp1, cp2;
    assign cp0 = sm[0][0] * minor_reg[0];
    assign cp1 = sm[0][1] * minor_reg[1];
    assign cp2 = sm[0][2] * minor_reg[2];

    logic signed [CW-1:0] csum;
    always_comb
    begin
        csum = CW'(cp0) - CW'(cp1) + CW'(cp2);
        if (dr[0] ^ dc[0])
        begin
            csum = -csum;
        end
    end

    // Determinant term: input (i,0) times cofactor index i*4
    logic signed [IN_WIDTH+CW-1:0] dprod;
    logic signed [DW-1:0]          dterm;
    assign dprod = m_reg[{2'b00, idx_reg[1:0]}] * cof_reg[{idx_reg[1:0], 2'b00}];
    assign dterm = DW'(dprod);

    // Divider step
    logic [QW:0]   rsh;
    logic          rge;
    assign rsh = {rem_reg, num_reg[bit_reg[QCW-1:0] - 1'b1]};
    assign rge = rsh >= (QW+1)'(dmag_reg);

    logic signed [CW-1:0] cur_cof;
    logic [NW-1:0]        nmag;
    assign cur_cof = cof_reg[idx_reg];
    assign nmag = cur_cof[CW-1] ? NW'(-cur_cof) << FracShift : NW'(cur_cof) << FracShift;

    // Saturation
    logic [QW-1:0]        lim;
    logic                 over;
    assign lim  = qneg_reg ? (QW'(1) << (OUT_WIDTH-1)) : ((QW'(1) << (OUT_WIDTH-1)) - 1'b1);
    assign over = quo_reg > lim;

    logic out_free;
    assign out_free = !ovalid_reg || !out_stall;
    assign eng_busy = state_reg != S_IDLE;
    assign mat_take = state_reg == S_IDLE && mat_valid;

    always_ff @(posedge clk)
    begin
        if (mat_take)
        begin
            for (int i = 0; i < 16; i++)
            begin
                m_reg[i] <= mat_data[i*IN_WIDTH +: IN_WIDTH];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
            step_reg   <= '0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (mat_valid)
                    begin
                        state_reg <= S_COF;
                        idx_reg   <= '0;
                        step_reg  <= '0;
                    end
                end
                S_COF:
                begin
                    if (step_reg == 2'd0)
                    begin
                        minor_reg[0] <= mn0;
                        minor_reg[1] <= mn1;
                        minor_reg[2] <= mn2;
                        step_reg     <= 2'd1;
                    end
                    else
                    begin
                        cof_reg[idx_reg] <= csum;
                        step_reg         <= 2'd0;
                        idx_reg          <= idx_reg + 4'd1;
                        if (idx_reg == 4'd15)
                        begin
                            state_reg <= S_DET;
                            det_reg   <= '0;
                        end
                    end
                end
                S_DET:
                begin
                    det_reg <= det_reg + dterm;
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg == 4'd3)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_DIV;
                        step_reg  <= '0;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == 2'd0)
                    begin
                        // load numerator for this element
                        dmag_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
                        num_reg  <= nmag;
                        qneg_reg <= cur_cof[CW-1] ^ det_reg[DW-1];
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        bit_reg  <= QCW'(NW);
                        step_reg <= (det_reg == '0) ? 2'd2 : 2'd1;
                    end
                    else if (step_reg == 2'd1)
                    begin
                        rem_reg <= rge ? QW'(rsh - (QW+1)'(dmag_reg)) : QW'(rsh);
                        quo_reg <= {quo_reg[QW-2:0], rge};
                        bit_reg <= bit_reg - 1'b1;
                        if (bit_reg == QCW'(1))
                        begin
                            step_reg <= 2'd2;
                        end
                    end
                    else if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        oidx_reg   <= idx_reg;
                        osing_reg  <= det_reg == '0;
                        if (det_reg == '0)
                        begin
                            oval_reg <= '0;
                            osat_reg <= 1'b0;
                        end
                        else
                        begin
                            osat_reg <= over;
                            oval_reg <= qneg_reg ? OUT_WIDTH'(-(over ? lim : quo_reg))
                                                 : OUT_WIDTH'(over ? lim : quo_reg);
                        end
                        step_reg <= '0;
                        idx_reg  <= idx_reg + 4'd1;
                        if (idx_reg == 4'd15)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = ovalid_reg;
    assign inverse_value = oval_reg;
    assign element_index = oidx_reg;
    assign singular      = osing_reg;
    assign saturated     = osat_reg;
    assign last          = oidx_reg == 4'd15;

endmodule

@@ sv/matrix4_inverse_adjugate.sv @@
`timescale 1ns / 1ps
// 4x4 matrix inverse by the adjugate, in fixed point with exact cofactors.
// Input channel: in_valid / in_stall carry one signed Q8.8 element per
// transfer, column-major, sixteen per matrix. Output channel: out_valid /
// out_stall carry sixteen Q16.16 results per matrix in column-major order,
// with element_index, singular, saturated and last.
// The loader takes one element a cycle while it is not holding a full
// matrix. Once sixteen are held they pass to the compute engine, and the
// loader can fill the next matrix meanwhile. The engine forms the sixteen
// cofactors, each from its three 2x2 minors and then their products, then
// the determinant along the first column, then for each result loads the
// numerator, runs a restoring divider one quotient bit per cycle and
// writes the result. The engine takes the next matrix only once its
// sixteenth result is written.
// A singular matrix skips the divider: 16 results of value 0, singular set.
// Reset clears the element count, the engine state and the output valid.
// When out_stall is high a valid result holds and the engine waits before
// writing the next one; the loader stalls the input only once a full matrix is waiting.
module matrix4_inverse_adjugate
    import mia_pkg::*;
#(
    parameter int IN_WIDTH  = 16,
    parameter int OUT_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IN_WIDTH-1:0]  element_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_WIDTH-1:0] inverse_value,
    output logic [3:0]           element_index,
    output logic                 singular,
    output logic                 saturated,
    output logic                 last
);

    logic                   mat_valid;
    logic [16*IN_WIDTH-1:0] mat_data;
    logic                   mat_take;
    logic                   eng_busy;

    mia_loader #(.IN_WIDTH(IN_WIDTH)) u_loader
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (element_value),
        .eng_busy  (eng_busy),
        .in_stall  (in_stall),
        .mat_valid (mat_valid),
        .mat_data  (mat_data),
        .mat_take  (mat_take)
    );

    mia_engine #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .mat_valid     (mat_valid),
        .mat_data      (mat_data),
        .mat_take      (mat_take),
        .eng_busy      (eng_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .inverse_value (inverse_value),
        .element_index (element_index),
        .singular      (singular),
        .saturated     (saturated),
        .last          (last)
    );

endmodule
